// File: design/aging_route_table_unit_assert.svh
// ----------------------------------------------------------------------------
// aging route table assertion macros
// shared property wrappers for the route table rtl, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef AGING_ROUTE_TABLE_UNIT_ASSERT_SVH
`define AGING_ROUTE_TABLE_UNIT_ASSERT_SVH

// clocked check, masked while reset is asserted
`define ART_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ART_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// field widths, result codes and record types of the aging route table
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

    localparam int CALL_W    = 56;
    localparam int RSSI_W    = 9;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int REMOVED_W = 7;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd120000;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SWEEP   = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]        last_seen;
        logic signed [RSSI_W-1:0] rssi;
        logic [CALL_W-1:0]        hop;
        logic [CALL_W-1:0]        dest;
    } t_entry;

    typedef struct packed {
        logic [REMOVED_W-1:0] removed;
        logic [SLOT_W-1:0]    slot;
        logic [STATUS_W-1:0]  status;
    } t_result;

endpackage

`default_nettype wire

// File: design/art_ram.sv
// ----------------------------------------------------------------------------
// art_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/art_cmp.sv
// ----------------------------------------------------------------------------
// art_cmp
// shared compare unit: callsign match for updates, age check for sweeps
// ----------------------------------------------------------------------------
`default_nettype none

module art_cmp (
    input  wire logic                        i_sweep,
    input  wire logic [art_pkg::CALL_W-1:0]  i_dest_a,
    input  wire logic [art_pkg::CALL_W-1:0]  i_dest_b,
    input  wire logic [art_pkg::TIME_W-1:0]  i_now,
    input  wire logic [art_pkg::TIME_W-1:0]  i_last_seen,
    input  wire logic [art_pkg::TIME_W-1:0]  i_timeout,
    output logic                             o_hit
);

    logic [art_pkg::TIME_W-1:0] age;

    // wrapping age, a time behind last_seen reads as very old
    assign age   = i_now - i_last_seen;
    assign o_hit = i_sweep ? (age > i_timeout) : (i_dest_a == i_dest_b);

endmodule

`default_nettype wire

// File: design/aging_route_table_unit.sv
// ----------------------------------------------------------------------------
// aging_route_table_unit
// route table with callsign lookup, lowest free slot insert and age sweep
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s (item)  in   i_s_tvalid / o_s_tready       i_s_tdata, i_s_tuser (cmd)
//  m (result)out  o_m_tvalid / i_m_tready       o_m_tdata
//  cfg       in   i_cfg_valid / o_cfg_ready     i_cfg_data (route timeout ms)
//
//  the result is registered after the table scan that follows the input transfer,
//  and the next input is taken only once the unit is back in idle; an update
//  that hits a valid entry ends the scan at that entry.
//  the entry ram has one read port and the sequencer walks it one entry per
//  cycle through one compare unit.
//  valid bits are flops cleared by reset, so there is no clearing pass.
//  input and config are taken only while idle and out of reset; a finished
//  result waits in the finish state while the output register is not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aging_route_table_unit_assert.svh"

module aging_route_table_unit #(
    parameter int ROUTE_ENTRIES = 20
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // dest_call[55:0], hop_call[111:56], rssi[120:112], now_ms[152:121], zero fill
    input  wire logic [159:0] i_s_tdata,
    // cmd[0]
    input  wire logic [0:0]   i_s_tuser,
    // master stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // status[1:0], slot[7:2], removed_count[14:8], zero fill
    output logic [15:0]       o_m_tdata,
    // configuration
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ROUTE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(ROUTE_ENTRIES);
    localparam logic [art_pkg::SLOT_W-1:0] SLOT_LAST = art_pkg::SLOT_W'(ROUTE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // control state
    logic [1:0]               r_state, n_state;
    logic [ROUTE_ENTRIES-1:0] r_valid, n_valid;
    logic                     r_cmp_vld, n_cmp_vld;
    logic                     r_out_vld, n_out_vld;
    logic [art_pkg::TIME_W-1:0] r_timeout, n_timeout;

    // working registers
    logic                       r_cmd, n_cmd;
    logic [art_pkg::CALL_W-1:0] r_dest, n_dest;
    logic [art_pkg::CALL_W-1:0] r_hop, n_hop;
    logic signed [art_pkg::RSSI_W-1:0] r_rssi, n_rssi;
    logic [art_pkg::TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]           r_rd_cnt, n_rd_cnt;
    logic [IDX_W-1:0]           r_cmp_idx, n_cmp_idx;
    logic                       r_found, n_found;
    logic [IDX_W-1:0]           r_hit_idx, n_hit_idx;
    logic                       r_free_found, n_free_found;
    logic [IDX_W-1:0]           r_free_idx, n_free_idx;
    logic [CNT_W-1:0]           r_removed, n_removed;
    art_pkg::t_result           r_out, n_out;

    logic             rd_en;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    art_pkg::t_entry  wr_entry;
    art_pkg::t_entry  rd_entry;
    logic             hit;

    logic             chk_scan;
    logic             chk_slotted;
    logic             chk_upd;
    logic             s_take;

    assign rd_en = (r_state == S_SCAN) && (r_rd_cnt < CNT_DEPTH);
    assign raddr = r_rd_cnt[IDX_W-1:0];

    assign wr_entry.dest      = r_dest;
    assign wr_entry.hop       = r_hop;
    assign wr_entry.rssi      = r_rssi;
    assign wr_entry.last_seen = r_now;

    art_ram #(
        .WIDTH ($bits(art_pkg::t_entry)),
        .DEPTH (ROUTE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rd_entry)
    );

    art_cmp u_cmp (
        .i_sweep     (r_cmd == art_pkg::CMD_SWEEP),
        .i_dest_a    (rd_entry.dest),
        .i_dest_b    (r_dest),
        .i_now       (r_now),
        .i_last_seen (rd_entry.last_seen),
        .i_timeout   (r_timeout),
        .o_hit       (hit)
    );

    assign o_s_tready  = i_rst_n && (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = {1'b0, r_out};
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_cmp_vld    = r_cmp_vld;
        n_out_vld    = r_out_vld;
        n_timeout    = r_timeout;
        n_cmd        = r_cmd;
        n_dest       = r_dest;
        n_hop        = r_hop;
        n_rssi       = r_rssi;
        n_now        = r_now;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_idx    = r_cmp_idx;
        n_found      = r_found;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_removed    = r_removed;
        n_out        = r_out;
        we           = 1'b0;
        waddr        = r_hit_idx;

        if (i_cfg_valid && o_cfg_ready) begin
            n_timeout = i_cfg_data;
        end

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd        = i_s_tuser[0];
                    n_dest       = i_s_tdata[55:0];
                    n_hop        = i_s_tdata[111:56];
                    n_rssi       = i_s_tdata[120:112];
                    n_now        = i_s_tdata[152:121];
                    n_rd_cnt     = '0;
                    n_cmp_vld    = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_removed    = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                n_cmp_vld = rd_en;
                n_cmp_idx = raddr;
                if (r_cmp_vld) begin
                    if (r_cmd == art_pkg::CMD_SWEEP) begin
                        if (r_valid[r_cmp_idx] && hit) begin
                            n_valid[r_cmp_idx] = 1'b0;
                            n_removed          = r_removed + 1'b1;
                        end
                    end else if (r_valid[r_cmp_idx] && hit) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_state   = S_FINISH;
                        n_cmp_vld = 1'b0;
                    end else if (!r_valid[r_cmp_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                    if (r_cmp_idx == IDX_LAST) begin
                        n_state   = S_FINISH;
                        n_cmp_vld = 1'b0;
                    end
                end
            end
            S_FINISH: begin
                // result register must be free before the table is touched
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_cmd == art_pkg::CMD_SWEEP) begin
                        n_out.status  = art_pkg::ST_SWEEP;
                        n_out.slot    = '0;
                        n_out.removed = art_pkg::REMOVED_W'(r_removed);
                    end else if (r_found) begin
                        we            = 1'b1;
                        waddr         = r_hit_idx;
                        n_out.status  = art_pkg::ST_REFRESH;
                        n_out.slot    = art_pkg::SLOT_W'(r_hit_idx);
                        n_out.removed = '0;
                    end else if (r_free_found) begin
                        we                  = 1'b1;
                        waddr               = r_free_idx;
                        n_valid[r_free_idx] = 1'b1;
                        n_out.status        = art_pkg::ST_INSERT;
                        n_out.slot          = art_pkg::SLOT_W'(r_free_idx);
                        n_out.removed       = '0;
                    end else begin
                        n_out.status  = art_pkg::ST_FULL;
                        n_out.slot    = '0;
                        n_out.removed = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_timeout <= art_pkg::TIMEOUT_RESET;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
            r_timeout <= n_timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_dest       <= n_dest;
        r_hop        <= n_hop;
        r_rssi       <= n_rssi;
        r_now        <= n_now;
        r_rd_cnt     <= n_rd_cnt;
        r_cmp_idx    <= n_cmp_idx;
        r_found      <= n_found;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_removed    <= n_removed;
        r_out        <= n_out;
    end

    assign chk_scan    = (r_state == S_SCAN);
    assign chk_slotted = r_out_vld && ((r_out.status == art_pkg::ST_REFRESH) ||
                                       (r_out.status == art_pkg::ST_INSERT));
    assign chk_upd     = r_out_vld && (r_out.status != art_pkg::ST_SWEEP);
    assign s_take      = i_s_tvalid && o_s_tready;

    `ART_ASSERT(a_removed_bound, chk_scan |-> (r_removed <= CNT_DEPTH), "removed count overflow")
    `ART_ASSERT(a_slot_in_range, chk_slotted |-> (r_out.slot <= SLOT_LAST), "slot beyond table")
    `ART_ASSERT(a_update_no_removed, chk_upd |-> (r_out.removed == '0), "removed on update")
    `ART_ASSERT(a_busy_after_take, s_take |=> (!o_s_tready && !we), "not busy after transfer")

endmodule

`default_nettype wire
